[hdl/se3nma_pkg.sv]
package se3nma_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int WEIGHT_WIDTH = 16;
    localparam int ROUND_SHIFT  = 12;
    localparam int RND_W        = COORD_WIDTH + WEIGHT_WIDTH + 2;
    localparam int A_W          = COORD_WIDTH + 6;
    localparam int PROD_W       = 2 * A_W;
    localparam int EXT_W        = (PROD_W > 65) ? PROD_W : 65;
    localparam int SUM_W        = 64;
    localparam int SUM_COUNT    = 10;
    localparam int DIM          = 6;
    localparam int IDX_W        = 3;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;

    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(2 ** (ROUND_SHIFT - 1));

    typedef logic signed [SUM_W-1:0] t_sum;

    localparam t_sum SUM_MAX = {1'b0, {(SUM_W - 1){1'b1}}};
    localparam t_sum SUM_MIN = {1'b1, {(SUM_W - 1){1'b0}}};

    typedef enum logic [3:0] {
        S_BBCC = 4'd0,
        S_AACC = 4'd1,
        S_AABB = 4'd2,
        S_AB   = 4'd3,
        S_AC   = 4'd4,
        S_BC   = 4'd5,
        S_AW   = 4'd6,
        S_BW   = 4'd7,
        S_CW   = 4'd8,
        S_WW   = 4'd9
    } t_sum_sel;

    typedef enum logic [1:0] {
        E_ZERO = 2'd0,
        E_POS  = 2'd1,
        E_NEG  = 2'd2
    } t_ekind;

    typedef struct packed {
        t_ekind   kind;
        t_sum_sel sel;
    } t_map_ent;

    typedef struct packed {
        logic [SUM_COUNT-1:0][SUM_W-1:0] term;
        logic                            last;
    } t_item;

    function automatic t_sum sat_add(input t_sum p, input t_sum q);
        logic signed [SUM_W:0] s;
        s = {p[SUM_W-1], p} + {q[SUM_W-1], q};
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic t_sum sat_neg(input t_sum v);
        if (v == SUM_MIN) begin
            return SUM_MAX;
        end
        return -v;
    endfunction

    function automatic t_sum sat_wide(input logic signed [EXT_W-1:0] v);
        logic [EXT_W-SUM_W:0] top;
        top = v[EXT_W-1:SUM_W-1];
        if ((&top) || !(|top)) begin
            return v[SUM_W-1:0];
        end
        return v[EXT_W-1] ? SUM_MIN : SUM_MAX;
    endfunction

    function automatic t_map_ent entry_map(input logic [IDX_W-1:0] row,
                                           input logic [IDX_W-1:0] col);
        t_map_ent e;
        e = '{E_ZERO, S_BBCC};
        case ({row, col})
            6'o00: e = '{E_POS, S_BBCC};
            6'o01: e = '{E_NEG, S_AB};
            6'o02: e = '{E_NEG, S_AC};
            6'o04: e = '{E_NEG, S_CW};
            6'o05: e = '{E_POS, S_BW};
            6'o10: e = '{E_NEG, S_AB};
            6'o11: e = '{E_POS, S_AACC};
            6'o12: e = '{E_NEG, S_BC};
            6'o13: e = '{E_POS, S_CW};
            6'o15: e = '{E_NEG, S_AW};
            6'o20: e = '{E_NEG, S_AC};
            6'o21: e = '{E_NEG, S_BC};
            6'o22: e = '{E_POS, S_AABB};
            6'o23: e = '{E_NEG, S_BW};
            6'o24: e = '{E_POS, S_AW};
            6'o31: e = '{E_POS, S_CW};
            6'o32: e = '{E_NEG, S_BW};
            6'o33: e = '{E_POS, S_WW};
            6'o40: e = '{E_NEG, S_CW};
            6'o42: e = '{E_POS, S_AW};
            6'o44: e = '{E_POS, S_WW};
            6'o50: e = '{E_POS, S_BW};
            6'o51: e = '{E_NEG, S_AW};
            6'o55: e = '{E_POS, S_WW};
            default: e = '{E_ZERO, S_BBCC};
        endcase
        return e;
    endfunction

endpackage

[hdl/se3nma_if.sv]
interface se3nma_in_if;
    import se3nma_pkg::*;

    logic                           valid;
    logic                           ready;
    logic signed [COORD_WIDTH-1:0]  coord_x;
    logic signed [COORD_WIDTH-1:0]  coord_y;
    logic signed [COORD_WIDTH-1:0]  coord_z;
    logic        [WEIGHT_WIDTH-1:0] point_weight;
    logic                           last_point;

    modport source (
        output valid, coord_x, coord_y, coord_z, point_weight, last_point,
        input  ready
    );

    modport sink (
        input  valid, coord_x, coord_y, coord_z, point_weight, last_point,
        output ready
    );
endinterface

interface se3nma_out_if;
    import se3nma_pkg::*;

    logic                    valid;
    logic                    ready;
    logic        [IDX_W-1:0] row_index;
    logic        [IDX_W-1:0] col_index;
    logic signed [SUM_W-1:0] entry_value;
    logic                    last_entry;

    modport source (
        output valid, row_index, col_index, entry_value, last_entry,
        input  ready
    );

    modport sink (
        input  valid, row_index, col_index, entry_value, last_entry,
        output ready
    );
endinterface

[hdl/se3nma_front.sv]
module se3nma_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    se3nma_in_if.sink         i_pts,
    output logic              o_push_valid,
    output se3nma_pkg::t_item o_push_item,
    input  logic              i_q_full
);
    import se3nma_pkg::*;

    function automatic logic signed [A_W-1:0] round_q(
        input logic signed [COORD_WIDTH-1:0]  v,
        input logic        [WEIGHT_WIDTH-1:0] w
    );
        logic signed [COORD_WIDTH+WEIGHT_WIDTH:0] p;
        logic signed [RND_W-1:0]                  t;
        p = v * $signed({1'b0, w});
        t = RND_W'(p) + RND_HALF;
        return A_W'(t >>> ROUND_SHIFT);
    endfunction

    logic                           w_adv;

    logic                           r_s1_valid;
    logic signed [A_W-1:0]          r_a;
    logic signed [A_W-1:0]          r_b;
    logic signed [A_W-1:0]          r_c;
    logic        [WEIGHT_WIDTH-1:0] r_w;
    logic                           r_s1_last;

    logic signed [PROD_W-1:0]         w_aa, w_bb, w_cc, w_ab, w_ac, w_bc;
    logic signed [A_W+WEIGHT_WIDTH:0] w_aw, w_bw, w_cw;
    logic        [2*WEIGHT_WIDTH-1:0] w_ww;
    t_item                            n_s2;

    logic                           r_s2_valid;
    t_item                          r_s2;

    t_item                          n_s3;
    logic                           r_s3_valid;
    t_item                          r_s3;

    assign w_adv       = !r_s3_valid || !i_q_full;
    assign i_pts.ready = w_adv;

    assign w_aa = r_a * r_a;
    assign w_bb = r_b * r_b;
    assign w_cc = r_c * r_c;
    assign w_ab = r_a * r_b;
    assign w_ac = r_a * r_c;
    assign w_bc = r_b * r_c;
    assign w_aw = r_a * $signed({1'b0, r_w});
    assign w_bw = r_b * $signed({1'b0, r_w});
    assign w_cw = r_c * $signed({1'b0, r_w});
    assign w_ww = r_w * r_w;

    // hold the squares in the pair slots until they are summed
    always_comb begin
        n_s2               = '0;
        n_s2.term[S_BBCC]  = sat_wide(EXT_W'(w_aa));
        n_s2.term[S_AACC]  = sat_wide(EXT_W'(w_bb));
        n_s2.term[S_AABB]  = sat_wide(EXT_W'(w_cc));
        n_s2.term[S_AB]    = sat_wide(EXT_W'(w_ab));
        n_s2.term[S_AC]    = sat_wide(EXT_W'(w_ac));
        n_s2.term[S_BC]    = sat_wide(EXT_W'(w_bc));
        n_s2.term[S_AW]    = sat_wide(EXT_W'(w_aw));
        n_s2.term[S_BW]    = sat_wide(EXT_W'(w_bw));
        n_s2.term[S_CW]    = sat_wide(EXT_W'(w_cw));
        n_s2.term[S_WW]    = {{(SUM_W - 2 * WEIGHT_WIDTH){1'b0}}, w_ww};
        n_s2.last          = r_s1_last;
    end

    always_comb begin
        n_s3              = r_s2;
        n_s3.term[S_BBCC] = sat_add(r_s2.term[S_AACC], r_s2.term[S_AABB]);
        n_s3.term[S_AACC] = sat_add(r_s2.term[S_BBCC], r_s2.term[S_AABB]);
        n_s3.term[S_AABB] = sat_add(r_s2.term[S_BBCC], r_s2.term[S_AACC]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_pts.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a       <= round_q(i_pts.coord_x, i_pts.point_weight);
            r_b       <= round_q(i_pts.coord_y, i_pts.point_weight);
            r_c       <= round_q(i_pts.coord_z, i_pts.point_weight);
            r_w       <= i_pts.point_weight;
            r_s1_last <= i_pts.last_point;
            r_s2      <= n_s2;
            r_s3      <= n_s3;
        end
    end

    assign o_push_valid = r_s3_valid;
    assign o_push_item  = r_s3;

endmodule

[hdl/se3nma_fifo.sv]
module se3nma_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  se3nma_pkg::t_item i_push_item,
    output logic              o_full,
    output logic              o_pop_valid,
    output se3nma_pkg::t_item o_pop_item,
    input  logic              i_pop_ready
);
    import se3nma_pkg::*;

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_full      = (r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_pop_valid = (r_cnt != '0);
    assign o_pop_item  = r_mem[r_rd];
    assign w_push      = i_push_valid && !o_full;
    assign w_pop       = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

endmodule

[hdl/se3nma_back.sv]
module se3nma_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    input  se3nma_pkg::t_item i_pop_item,
    output logic              o_pop_ready,
    se3nma_out_if.source      o_mat
);
    import se3nma_pkg::*;

    t_sum             r_sums [SUM_COUNT];
    logic             r_emit;
    logic [IDX_W-1:0] r_row;
    logic [IDX_W-1:0] r_col;
    logic             r_ovalid;
    logic [IDX_W-1:0] r_orow;
    logic [IDX_W-1:0] r_ocol;
    t_sum             r_oval;
    logic             r_olast;

    logic             w_pop;
    logic             w_out_free;
    logic             w_step;
    logic             w_last_ent;
    t_map_ent         w_ent;
    t_sum             n_oval;

    assign o_pop_ready = !r_emit;
    assign w_pop       = i_pop_valid && !r_emit;
    assign w_out_free  = !r_ovalid || o_mat.ready;
    assign w_step      = r_emit && w_out_free;
    assign w_last_ent  = (r_row == IDX_W'(DIM - 1)) && (r_col == IDX_W'(DIM - 1));
    assign w_ent       = entry_map(r_row, r_col);

    always_comb begin
        case (w_ent.kind)
            E_POS:   n_oval = r_sums[w_ent.sel];
            E_NEG:   n_oval = sat_neg(r_sums[w_ent.sel]);
            default: n_oval = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < SUM_COUNT; i++) begin
                r_sums[i] <= '0;
            end
        end else begin
            if (r_ovalid && o_mat.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_pop) begin
                for (int i = 0; i < SUM_COUNT; i++) begin
                    r_sums[i] <= sat_add(r_sums[i], i_pop_item.term[i]);
                end
                if (i_pop_item.last) begin
                    r_emit <= 1'b1;
                end
            end
            if (w_step) begin
                r_ovalid <= 1'b1;
                if (w_last_ent) begin
                    r_emit <= 1'b0;
                    for (int i = 0; i < SUM_COUNT; i++) begin
                        r_sums[i] <= '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_step) begin
            if (r_col == IDX_W'(DIM - 1)) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
        if (w_step) begin
            r_orow  <= r_row;
            r_ocol  <= r_col;
            r_oval  <= n_oval;
            r_olast <= w_last_ent;
        end
    end

    assign o_mat.valid       = r_ovalid;
    assign o_mat.row_index   = r_orow;
    assign o_mat.col_index   = r_ocol;
    assign o_mat.entry_value = r_oval;
    assign o_mat.last_entry  = r_olast;

endmodule

[hdl/se3_twist_normal_matrix_accumulator_unit.sv]
// Throughput: one point per cycle while the queue has room; a three-stage product pipeline
// feeds a 4-deep queue. Matrix output: 36 entries, one per cycle through the output
// register while the sink is ready; the accumulator takes no point from the queue while
// it emits them, so input stalls once the queue is full.
// Reset: synchronous, active low; clears the moment sums, the queue and all valid flags.
module se3_twist_normal_matrix_accumulator_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    se3nma_in_if.sink    i_pts,
    se3nma_out_if.source o_mat
);
    import se3nma_pkg::*;

    logic  w_push_valid;
    t_item w_push_item;
    logic  w_q_full;
    logic  w_pop_valid;
    t_item w_pop_item;
    logic  w_pop_ready;

    se3nma_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pts        (i_pts),
        .o_push_valid (w_push_valid),
        .o_push_item  (w_push_item),
        .i_q_full     (w_q_full)
    );

    se3nma_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_item  (w_push_item),
        .o_full       (w_q_full),
        .o_pop_valid  (w_pop_valid),
        .o_pop_item   (w_pop_item),
        .i_pop_ready  (w_pop_ready)
    );

    se3nma_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .i_pop_item  (w_pop_item),
        .o_pop_ready (w_pop_ready),
        .o_mat       (o_mat)
    );

endmodule

[hdl/se3nma_checker.sv]
module se3nma_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                i_ready,
    input logic [se3nma_pkg::IDX_W-1:0]        i_row,
    input logic [se3nma_pkg::IDX_W-1:0]        i_col,
    input logic signed [se3nma_pkg::SUM_W-1:0] i_entry,
    input logic                                i_last
);
    import se3nma_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_entry) && $stable(i_row)
                                && $stable(i_col))
        else $error("stalled transaction changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_row <= IDX_W'(DIM - 1)) && (i_col <= IDX_W'(DIM - 1))
                    && (i_last == ((i_row == IDX_W'(DIM - 1)) && (i_col == IDX_W'(DIM - 1)))))
        else $error("bad entry position or last flag");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_row <= IDX_W'(DIM - 1)) && (i_col <= IDX_W'(DIM - 1))
        && (entry_map(i_row, i_col).kind == E_ZERO) |-> (i_entry == '0))
        else $error("structural zero entry not zero");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && !i_last |=> !i_valid
            || ((i_row == $past(i_row)) && (i_col == $past(i_col) + 1'b1))
            || ((i_row == $past(i_row) + 1'b1) && (i_col == '0)
                && ($past(i_col) == IDX_W'(DIM - 1))))
        else $error("entries out of row-major order");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("output valid after reset");

endmodule

bind se3_twist_normal_matrix_accumulator_unit se3nma_checker u_se3nma_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_mat.valid),
    .i_ready (o_mat.ready),
    .i_row   (o_mat.row_index),
    .i_col   (o_mat.col_index),
    .i_entry (o_mat.entry_value),
    .i_last  (o_mat.last_entry)
);
